// ===== src/clr_pkg.sv =====
package clr_pkg;

  // Defaults for the top-level parameters.
  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS_DEF = 32;

  // Depth of the command queue between decode and execution.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Frame size after reset.
  localparam int FRAME_W_RESET = 1024;
  localparam int FRAME_H_RESET = 768;

  // Item kinds.
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  // Control part of one decoded command.
  typedef struct packed {
    logic is_start;
    logic drop;
    logic straight;
    logic x_neg;
    logic y_neg;
  } ctl_t;

endpackage

// ===== src/clipped_line_rasterizer_top.sv =====
// An accepted item passes through the command queue and then the output
// register of the execution stage before its result is valid.
// Throughput: one item per cycle, start or advance, unless the result side
// stalls; the execution stage's pixel stepper updates its line state once per command.
// A two-entry command queue lets decode keep accepting while a result stalls.
// Reset (rst, synchronous) empties the queue and the output register, ends
// any line, and sets the frame size to 1024 by 768; no clearing pass is run.
module clipped_line_rasterizer_top
  import clr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COLOR_BITS = COLOR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // Input items.
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     kind,
  input  logic [COORD_BITS-1:0]    start_x,
  input  logic [COORD_BITS-1:0]    start_y,
  input  logic [COORD_BITS-1:0]    end_x,
  input  logic [COORD_BITS-1:0]    end_y,
  input  logic [COLOR_BITS-1:0]    pixel_color,
  // Result items.
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [COORD_BITS-1:0]    pixel_x,
  output logic [COORD_BITS-1:0]    pixel_y,
  output logic [COLOR_BITS-1:0]    color_out,
  output logic                     write_enable,
  output logic                     line_done,
  // Configuration port.
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  // The frame registers are one bit wider than a coordinate so that a frame
  // spanning the whole coordinate range clips nothing.
  localparam int FW_BITS  = COORD_BITS + 1;
  localparam int FW_MAX   = (1 << FW_BITS) - 1;
  localparam int W_RESET  = (FRAME_W_RESET < FW_MAX) ? FRAME_W_RESET : FW_MAX;
  localparam int H_RESET  = (FRAME_H_RESET < FW_MAX) ? FRAME_H_RESET : FW_MAX;
  localparam int Q_WIDTH  = $bits(ctl_t) + 6 * COORD_BITS + COLOR_BITS;

  logic [FW_BITS-1:0]    frame_width;
  logic [FW_BITS-1:0]    frame_height;
  logic                  cfg_write;
  logic                  reg_idx;

  // Decoded command from the front end.
  ctl_t                  f_ctl;
  logic [COORD_BITS-1:0] f_cur_x;
  logic [COORD_BITS-1:0] f_cur_y;
  logic [COORD_BITS-1:0] f_stop_x;
  logic [COORD_BITS-1:0] f_stop_y;
  logic [COORD_BITS-1:0] f_span_x;
  logic [COORD_BITS-1:0] f_span_y;

  // Command at the head of the queue.
  logic                  q_valid;
  logic                  q_ready;
  logic                  q_pop;
  ctl_t                  q_ctl;
  logic [COORD_BITS-1:0] q_cur_x;
  logic [COORD_BITS-1:0] q_cur_y;
  logic [COORD_BITS-1:0] q_stop_x;
  logic [COORD_BITS-1:0] q_stop_y;
  logic [COORD_BITS-1:0] q_span_x;
  logic [COORD_BITS-1:0] q_span_y;
  logic [COLOR_BITS-1:0] q_color;
  logic [Q_WIDTH-1:0]    q_wdata;
  logic [Q_WIDTH-1:0]    q_rdata;

  // Configuration registers. Every write lands at the register selected by
  // the word address; the byte offset bits are ignored.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_BITS'(W_RESET);
      frame_height <= FW_BITS'(H_RESET);
    end else if (cfg_write) begin
      if (reg_idx == REG_FRAME_WIDTH) begin
        frame_width <= pwdata[FW_BITS-1:0];
      end else begin
        frame_height <= pwdata[FW_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx == REG_FRAME_HEIGHT) begin
      prdata = APB_DATA_BITS'(frame_height);
    end else begin
      prdata = APB_DATA_BITS'(frame_width);
    end
  end

  // The front end classifies each item as it arrives: straight lines are
  // clipped here, and Bresenham lines get their step directions and spans.
  clr_front #(
    .COORD_BITS (COORD_BITS),
    .FW_BITS    (FW_BITS)
  ) u_front (
    .kind         (kind),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .ctl          (f_ctl),
    .cur_x        (f_cur_x),
    .cur_y        (f_cur_y),
    .stop_x       (f_stop_x),
    .stop_y       (f_stop_y),
    .span_x       (f_span_x),
    .span_y       (f_span_y)
  );

  assign q_wdata = {f_ctl, f_cur_x, f_cur_y, f_stop_x, f_stop_y, f_span_x, f_span_y,
                    pixel_color};
  assign {q_ctl, q_cur_x, q_cur_y, q_stop_x, q_stop_y, q_span_x, q_span_y,
          q_color} = q_rdata;

  // The queue decouples acceptance from execution. Its ready depends only on
  // its own fill level, so there is no path from out_ready to in_ready.
  clr_queue #(
    .WIDTH (Q_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (q_wdata),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_rdata)
  );

  assign q_pop = q_valid && q_ready;

  // The back end holds the line state and emits one result per command into
  // its output register.
  clr_back #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS),
    .FW_BITS    (FW_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_valid),
    .cmd_ready    (q_ready),
    .cmd_ctl      (q_ctl),
    .cmd_cur_x    (q_cur_x),
    .cmd_cur_y    (q_cur_y),
    .cmd_stop_x   (q_stop_x),
    .cmd_stop_y   (q_stop_y),
    .cmd_span_x   (q_span_x),
    .cmd_span_y   (q_span_y),
    .cmd_color    (q_color),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .color_out    (color_out),
    .write_enable (write_enable),
    .line_done    (line_done)
  );

  // A start command always produces an empty, unwritten pixel.
  a_start_result: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_ctl.is_start) |=>
      (out_valid && !write_enable && pixel_x == '0 && pixel_y == '0 && color_out == '0))
    else $error("start command produced a non-empty pixel");

  // A line dropped by clipping reports done at once.
  a_drop_done: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_ctl.is_start && q_ctl.drop) |=> line_done)
    else $error("dropped line did not report done");

  // The back end must not overwrite a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !q_pop)
    else $error("command popped while the output register was stalled");

endmodule

// ===== src/clr_front.sv =====
module clr_front
  import clr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FW_BITS    = COORD_BITS + 1
) (
  input  logic                  kind,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [FW_BITS-1:0]    frame_width,
  input  logic [FW_BITS-1:0]    frame_height,
  output ctl_t                  ctl,
  output logic [COORD_BITS-1:0] cur_x,
  output logic [COORD_BITS-1:0] cur_y,
  output logic [COORD_BITS-1:0] stop_x,
  output logic [COORD_BITS-1:0] stop_y,
  output logic [COORD_BITS-1:0] span_x,
  output logic [COORD_BITS-1:0] span_y
);

  logic                  horiz;
  logic                  vert;
  logic [COORD_BITS-1:0] lo;
  logic [COORD_BITS-1:0] hi;
  logic [COORD_BITS-1:0] hi_clip;
  logic [FW_BITS-1:0]    limit;
  logic [FW_BITS-1:0]    limit_m1;

  assign horiz = (start_y == end_y);
  assign vert  = (start_x == end_x);

  // A horizontal line runs along x, a vertical one along y.
  always_comb begin
    if (horiz) begin
      lo    = (start_x < end_x) ? start_x : end_x;
      hi    = (start_x < end_x) ? end_x : start_x;
      limit = frame_width;
    end else begin
      lo    = (start_y < end_y) ? start_y : end_y;
      hi    = (start_y < end_y) ? end_y : start_y;
      limit = frame_height;
    end
    limit_m1 = limit - FW_BITS'(1);
    hi_clip  = ({1'b0, hi} >= limit) ? limit_m1[COORD_BITS-1:0] : hi;
  end

  always_comb begin
    ctl.is_start = (kind == KIND_START);
    ctl.straight = horiz | vert;
    ctl.x_neg    = 1'b0;
    ctl.y_neg    = 1'b0;
    ctl.drop     = 1'b0;
    cur_x        = start_x;
    cur_y        = start_y;
    stop_x       = end_x;
    stop_y       = end_y;
    span_x       = '0;
    span_y       = '0;
    if (horiz) begin
      ctl.drop = ({1'b0, start_y} >= frame_height) || ({1'b0, lo} >= frame_width);
      cur_x    = lo;
      stop_x   = hi_clip;
      stop_y   = start_y;
    end else if (vert) begin
      ctl.drop = ({1'b0, start_x} >= frame_width) || ({1'b0, lo} >= frame_height);
      cur_y    = lo;
      stop_y   = hi_clip;
      stop_x   = start_x;
    end else begin
      ctl.x_neg = (end_x < start_x);
      ctl.y_neg = (end_y < start_y);
      span_x    = ctl.x_neg ? (start_x - end_x) : (end_x - start_x);
      span_y    = ctl.y_neg ? (start_y - end_y) : (end_y - start_y);
    end
  end

endmodule

// ===== src/clr_queue.sv =====
module clr_queue
  import clr_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                push;
  logic                pop;

  assign wr_ready = (count != CNT_BITS'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

// ===== src/clr_back.sv =====
module clr_back
  import clr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COLOR_BITS = COLOR_BITS_DEF,
  parameter int FW_BITS    = COORD_BITS + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  ctl_t                  cmd_ctl,
  input  logic [COORD_BITS-1:0] cmd_cur_x,
  input  logic [COORD_BITS-1:0] cmd_cur_y,
  input  logic [COORD_BITS-1:0] cmd_stop_x,
  input  logic [COORD_BITS-1:0] cmd_stop_y,
  input  logic [COORD_BITS-1:0] cmd_span_x,
  input  logic [COORD_BITS-1:0] cmd_span_y,
  input  logic [COLOR_BITS-1:0] cmd_color,
  input  logic [FW_BITS-1:0]    frame_width,
  input  logic [FW_BITS-1:0]    frame_height,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_BITS-1:0] color_out,
  output logic                  write_enable,
  output logic                  line_done
);

  localparam int ERR_BITS = COORD_BITS + 2;

  // Line state.
  logic                       running, running_next;
  logic                       straight, straight_next;
  logic                       x_neg, x_neg_next;
  logic                       y_neg, y_neg_next;
  logic [COORD_BITS-1:0]      cur_x, cur_x_next;
  logic [COORD_BITS-1:0]      cur_y, cur_y_next;
  logic [COORD_BITS-1:0]      stop_x, stop_x_next;
  logic [COORD_BITS-1:0]      stop_y, stop_y_next;
  logic [COORD_BITS-1:0]      span_x, span_x_next;
  logic [COORD_BITS-1:0]      span_y, span_y_next;
  logic signed [ERR_BITS-1:0] err, err_next;
  logic [COLOR_BITS-1:0]      line_color, line_color_next;

  // Result fields for the output register.
  logic [COORD_BITS-1:0]      res_x;
  logic [COORD_BITS-1:0]      res_y;
  logic [COLOR_BITS-1:0]      res_color;
  logic                       res_we;
  logic                       res_done;

  logic                       pop;
  logic                       last;
  logic                       step_x;
  logic                       step_y;
  logic signed [ERR_BITS:0]   e2;
  logic signed [ERR_BITS:0]   neg_span_y;
  logic signed [ERR_BITS:0]   pos_span_x;
  logic signed [ERR_BITS-1:0] sub_y;
  logic signed [ERR_BITS-1:0] add_x;

  assign cmd_ready = !out_valid || out_ready;
  assign pop       = cmd_valid && cmd_ready;

  assign last       = (cur_x == stop_x) && (cur_y == stop_y);
  assign e2         = {err, 1'b0};
  assign neg_span_y = -$signed({3'b000, span_y});
  assign pos_span_x = $signed({3'b000, span_x});
  assign step_x     = (e2 > neg_span_y);
  assign step_y     = (e2 < pos_span_x);
  assign sub_y      = step_x ? $signed({2'b00, span_y}) : '0;
  assign add_x      = step_y ? $signed({2'b00, span_x}) : '0;

  always_comb begin
    running_next    = running;
    straight_next   = straight;
    x_neg_next      = x_neg;
    y_neg_next      = y_neg;
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    stop_x_next     = stop_x;
    stop_y_next     = stop_y;
    span_x_next     = span_x;
    span_y_next     = span_y;
    err_next        = err;
    line_color_next = line_color;
    res_x           = '0;
    res_y           = '0;
    res_color       = '0;
    res_we          = 1'b0;
    res_done        = 1'b1;
    if (cmd_ctl.is_start) begin
      line_color_next = cmd_color;
      running_next    = !cmd_ctl.drop;
      res_done        = cmd_ctl.drop;
      straight_next   = cmd_ctl.straight;
      x_neg_next      = cmd_ctl.x_neg;
      y_neg_next      = cmd_ctl.y_neg;
      cur_x_next      = cmd_cur_x;
      cur_y_next      = cmd_cur_y;
      stop_x_next     = cmd_stop_x;
      stop_y_next     = cmd_stop_y;
      span_x_next     = cmd_span_x;
      span_y_next     = cmd_span_y;
      err_next        = $signed({2'b00, cmd_span_x}) - $signed({2'b00, cmd_span_y});
    end else if (running) begin
      res_x     = cur_x;
      res_y     = cur_y;
      res_color = line_color;
      res_we    = straight ||
                  (({1'b0, cur_x} < frame_width) && ({1'b0, cur_y} < frame_height));
      res_done  = last;
      if (last) begin
        running_next = 1'b0;
      end else if (straight) begin
        if (cur_x != stop_x) begin
          cur_x_next = cur_x + COORD_BITS'(1);
        end else begin
          cur_y_next = cur_y + COORD_BITS'(1);
        end
      end else begin
        err_next = err - sub_y + add_x;
        if (step_x) begin
          cur_x_next = x_neg ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
        end
        if (step_y) begin
          cur_y_next = y_neg ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        running   <= running_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      straight     <= straight_next;
      x_neg        <= x_neg_next;
      y_neg        <= y_neg_next;
      cur_x        <= cur_x_next;
      cur_y        <= cur_y_next;
      stop_x       <= stop_x_next;
      stop_y       <= stop_y_next;
      span_x       <= span_x_next;
      span_y       <= span_y_next;
      err          <= err_next;
      line_color   <= line_color_next;
      pixel_x      <= res_x;
      pixel_y      <= res_y;
      color_out    <= res_color;
      write_enable <= res_we;
      line_done    <= res_done;
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clr_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int KB = COLOR_BITS_DEF;
  localparam int COORD_MAX = (1 << CB) - 1;
  localparam int N_DIRECTED = 24;
  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 250;

  // One input item as it is driven onto the ports.
  typedef struct packed {
    logic          kind;
    logic [CB-1:0] sx;
    logic [CB-1:0] sy;
    logic [CB-1:0] ex;
    logic [CB-1:0] ey;
    logic [KB-1:0] color;
  } line_cmd_t;

  // One emitted pixel, the result of exactly one input item.
  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [KB-1:0] color;
    logic          we;
    logic          done;
  } pixel_t;

  // A row of the directed table. When "typed" is set, the pixel that follows
  // it is the one the block must return; otherwise the line tracker decides.
  typedef struct {
    logic          kind;
    int            sx, sy, ex, ey;
    logic [KB-1:0] color;
    bit            typed;
    int            px, py;
    logic [KB-1:0] pc;
    bit            we, done;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     kind = KIND_ADVANCE;
  logic [CB-1:0]            start_x = '0;
  logic [CB-1:0]            start_y = '0;
  logic [CB-1:0]            end_x = '0;
  logic [CB-1:0]            end_y = '0;
  logic [KB-1:0]            pixel_color = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [CB-1:0]            pixel_x;
  logic [CB-1:0]            pixel_y;
  logic [KB-1:0]            color_out;
  logic                     write_enable;
  logic                     line_done;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  clipped_line_rasterizer_top u_top (.*);

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Pixels still owed by the block, oldest first.
  pixel_t pixels_due[$];
  int     n_errors = 0;
  int     n_sent = 0;
  // While set, neither side inserts idle cycles.
  bit     no_gaps = 1'b0;

  // Shadow of the line state kept by the block. Frame size is held as an
  // integer so that values of 0 and above 4096 compare the way the block
  // compares them.
  int fw = FRAME_W_RESET;
  int fh = FRAME_H_RESET;
  bit ln_busy = 1'b0;
  bit ln_straight = 1'b0;
  int pos_x = 0, pos_y = 0, tgt_x = 0, tgt_y = 0;
  int dist_x = 0, dist_y = 0, err_acc = 0;
  bit neg_x = 1'b0, neg_y = 1'b0;
  logic [KB-1:0] ln_color = '0;

  // The directed table. Frame size is 1024 by 768 throughout it.
  dir_row_t dir_table [N_DIRECTED] = '{
    // Advance with no line active.
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 1, 0, 0, 32'h0, 0, 1},
    // Horizontal line entirely right of the frame is dropped.
    '{KIND_START, 2000, 10, 3000, 10, 32'hDEADBEEF, 1, 0, 0, 32'h0, 0, 1},
    // Vertical line on the first column past the frame is dropped.
    '{KIND_START, 1024, 0, 1024, 5, 32'h01234567, 1, 0, 0, 32'h0, 0, 1},
    // Horizontal line on the first row below the frame is dropped.
    '{KIND_START, 0, 768, 5, 768, 32'h89ABCDEF, 1, 0, 0, 32'h0, 0, 1},
    // Reversed horizontal line, clipped at the right edge of the frame.
    '{KIND_START, 1030, 5, 1020, 5, 32'hFFFFFFFF, 1, 0, 0, 32'h0, 0, 0},
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 1, 1020, 5, 32'hFFFFFFFF, 1, 0},
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 1, 1021, 5, 32'hFFFFFFFF, 1, 0},
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 1, 1022, 5, 32'hFFFFFFFF, 1, 0},
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 1, 1023, 5, 32'hFFFFFFFF, 1, 1},
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 1, 0, 0, 32'h0, 0, 1},
    // A single point at the origin.
    '{KIND_START, 0, 0, 0, 0, 32'h0, 1, 0, 0, 32'h0, 0, 0},
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 1, 0, 0, 32'h0, 1, 1},
    // Reversed vertical line runs from its lower y upward.
    '{KIND_START, 7, 3, 7, 0, 32'hA5A5A5A5, 1, 0, 0, 32'h0, 0, 0},
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 1, 7, 0, 32'hA5A5A5A5, 1, 0},
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 1, 7, 1, 32'hA5A5A5A5, 1, 0},
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 1, 7, 2, 32'hA5A5A5A5, 1, 0},
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 1, 7, 3, 32'hA5A5A5A5, 1, 1},
    // Diagonal from the far corner: its pixels lie outside the frame.
    '{KIND_START, 4095, 4095, 4090, 4093, 32'h5A5A5A5A, 0, 0, 0, 32'h0, 0, 0},
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 32'h0, 0, 0},
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 32'h0, 0, 0},
    // A new start abandons the line above in mid flight.
    '{KIND_START, 0, 4095, 4095, 0, 32'h12345678, 0, 0, 0, 32'h0, 0, 0},
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 32'h0, 0, 0},
    '{KIND_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 32'h0, 0, 0},
    // A diagonal crossing the bottom right corner, left running.
    '{KIND_START, 1023, 767, 1025, 770, 32'h0F0F0F0F, 0, 0, 0, 32'h0, 0, 0}
  };

  function automatic void flag_error(string what);
    if (n_errors < 10) begin
      $display("%0t ERROR: %s", $time, what);
    end
    n_errors++;
  endfunction

  // Works out the pixel that one input item produces, and moves the shadow
  // line state on exactly as the block does.
  function automatic pixel_t rasterize_step(line_cmd_t c);
    pixel_t r;
    int     lo, hi, e2;
    bit     at_end;
    r = '0;
    if (c.kind == KIND_START) begin
      ln_color = c.color;
      ln_busy = 1'b0;
      ln_straight = 1'b0;
      if (c.sy == c.ey || c.sx == c.ex) begin
        // Straight lines are clipped once, here, against the current frame.
        ln_straight = 1'b1;
        if (c.sy == c.ey) begin
          lo = int'((c.sx < c.ex) ? c.sx : c.ex);
          hi = int'((c.sx < c.ex) ? c.ex : c.sx);
          if (int'(c.sy) >= fh || lo >= fw) begin
            r.done = 1'b1;
            return r;
          end
          if (hi >= fw) hi = fw - 1;
          pos_x = lo;
          tgt_x = hi;
          pos_y = int'(c.sy);
          tgt_y = int'(c.sy);
        end else begin
          lo = int'((c.sy < c.ey) ? c.sy : c.ey);
          hi = int'((c.sy < c.ey) ? c.ey : c.sy);
          if (int'(c.sx) >= fw || lo >= fh) begin
            r.done = 1'b1;
            return r;
          end
          if (hi >= fh) hi = fh - 1;
          pos_y = lo;
          tgt_y = hi;
          pos_x = int'(c.sx);
          tgt_x = int'(c.sx);
        end
        dist_x = tgt_x - pos_x;
        dist_y = tgt_y - pos_y;
        err_acc = 0;
        neg_x = 1'b0;
        neg_y = 1'b0;
      end else begin
        neg_x = c.ex < c.sx;
        neg_y = c.ey < c.sy;
        dist_x = neg_x ? int'(c.sx) - int'(c.ex) : int'(c.ex) - int'(c.sx);
        dist_y = neg_y ? int'(c.sy) - int'(c.ey) : int'(c.ey) - int'(c.sy);
        err_acc = dist_x - dist_y;
        pos_x = int'(c.sx);
        pos_y = int'(c.sy);
        tgt_x = int'(c.ex);
        tgt_y = int'(c.ey);
      end
      ln_busy = 1'b1;
      return r;
    end
    if (!ln_busy) begin
      r.done = 1'b1;
      return r;
    end
    at_end = (pos_x == tgt_x) && (pos_y == tgt_y);
    r.x = CB'(pos_x);
    r.y = CB'(pos_y);
    r.color = ln_color;
    // Diagonal pixels see the frame size as it stands right now.
    r.we = ln_straight ? 1'b1 : (pos_x < fw && pos_y < fh);
    r.done = at_end;
    if (at_end) begin
      ln_busy = 1'b0;
      return r;
    end
    if (ln_straight) begin
      if (pos_x != tgt_x) pos_x = (pos_x + 1) & COORD_MAX;
      else pos_y = (pos_y + 1) & COORD_MAX;
      return r;
    end
    e2 = 2 * err_acc;
    if (e2 > -dist_y) begin
      err_acc -= dist_y;
      pos_x = (neg_x ? pos_x - 1 : pos_x + 1) & COORD_MAX;
    end
    if (e2 < dist_x) begin
      err_acc += dist_x;
      pos_y = (neg_y ? pos_y - 1 : pos_y + 1) & COORD_MAX;
    end
    return r;
  endfunction

  // Offers one item, starting at a falling edge, and returns at the falling
  // edge after it was taken. The expected pixel is queued at the edge of
  // acceptance, so the shadow state is always current when this returns.
  // Valid is lowered here only for random idle gaps; the caller drops it when the stream pauses.
  task automatic send_item(input line_cmd_t c, input bit typed = 1'b0,
                           input pixel_t want = '0);
    pixel_t got;
    while (!no_gaps && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= c.kind;
    start_x     <= c.sx;
    start_y     <= c.sy;
    end_x       <= c.ex;
    end_y       <= c.ey;
    pixel_color <= c.color;
    do @(posedge clk); while (!in_ready);
    got = rasterize_step(c);
    pixels_due.push_back(typed ? want : got);
    n_sent++;
    @(negedge clk);
  endtask

  // An advance item. Its coordinate and color fields carry random values,
  // which the block must ignore.
  task automatic send_advance();
    line_cmd_t  c;
    logic [95:0] rnd;
    rnd = {$urandom(), $urandom(), $urandom()};
    c = rnd[$bits(line_cmd_t)-1:0];
    c.kind = KIND_ADVANCE;
    send_item(c);
  endtask

  // One APB write followed by a read back, starting and ending at a falling
  // edge. Only called while no pixel is owed.
  task automatic write_frame_reg(input logic idx, input int val);
    logic [APB_DATA_BITS-1:0] word;
    word = APB_DATA_BITS'(val & 'h1FFF);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_FRAME_WIDTH) fw = int'(word);
    else fh = int'(word);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== word) begin
      flag_error($sformatf("register %0d read back %h, expected %h", idx, prdata, word));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // Start coordinates bunch up at the origin, the far corner and the frame
  // edge, where clipping decisions flip.
  function automatic int pick_coord(int lim);
    case ($urandom_range(3))
      0: return $urandom_range(COORD_MAX);
      1: return $urandom_range(15);
      2: return clamp_coord(lim - 8 + int'($urandom_range(16)));
      default: return COORD_MAX - int'($urandom_range(15));
    endcase
  endfunction

  function automatic int near_coord(int v);
    return clamp_coord(v - 24 + int'($urandom_range(48)));
  endfunction

  // One well formed line: a start, then advances until the line ends, with
  // some lines cut short and some followed by advances on an idle block.
  task automatic run_line();
    line_cmd_t c;
    int        cap;
    c.kind = KIND_START;
    c.sx = CB'(pick_coord(fw));
    c.sy = CB'(pick_coord(fh));
    case ($urandom_range(9))
      0, 1: begin
        c.ey = c.sy;
        c.ex = CB'(near_coord(int'(c.sx)));
      end
      2, 3: begin
        c.ex = c.sx;
        c.ey = CB'(near_coord(int'(c.sy)));
      end
      4: begin
        c.ex = CB'($urandom_range(COORD_MAX));
        c.ey = CB'($urandom_range(COORD_MAX));
      end
      default: begin
        c.ex = CB'(near_coord(int'(c.sx)));
        c.ey = CB'(near_coord(int'(c.sy)));
      end
    endcase
    c.color = $urandom();
    send_item(c);
    cap = ($urandom_range(9) == 0) ? $urandom_range(6) : 64;
    while (ln_busy && cap > 0) begin
      send_advance();
      cap--;
    end
    repeat ($urandom_range(1)) send_advance();
  endtask

  // Blocks until every owed pixel has arrived, then lets the pipeline settle
  // before a register is touched.
  task automatic drain();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: ready drops at random, except during the quiet phase.
  always @(negedge clk) begin
    out_ready <= no_gaps || ($urandom_range(99) >= 34);
  end

  // Every accepted pixel is held against the oldest owed pixel.
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        flag_error($sformatf("unexpected pixel x=%0d y=%0d", pixel_x, pixel_y));
      end else begin
        want = pixels_due.pop_front();
        if (pixel_x !== want.x || pixel_y !== want.y || color_out !== want.color ||
            write_enable !== want.we || line_done !== want.done) begin
          flag_error($sformatf(
            {"pixel mismatch: got x=%0d y=%0d c=%h we=%b done=%b, ",
             "want x=%0d y=%0d c=%h we=%b done=%b"},
            pixel_x, pixel_y, color_out, write_enable, line_done,
            want.x, want.y, want.color, want.we, want.done));
        end
      end
    end
  end

  // Main sequence: reset, the directed table at the reset frame size, then a
  // series of random phases, each under its own frame size.
  initial begin : stimulus
    line_cmd_t   c;
    pixel_t      want;
    int          phase_end;
    int          w, h;
    logic [95:0] rnd;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_table[i]) begin
      c.kind  = dir_table[i].kind;
      c.sx    = CB'(dir_table[i].sx);
      c.sy    = CB'(dir_table[i].sy);
      c.ex    = CB'(dir_table[i].ex);
      c.ey    = CB'(dir_table[i].ey);
      c.color = dir_table[i].color;
      want.x     = CB'(dir_table[i].px);
      want.y     = CB'(dir_table[i].py);
      want.color = dir_table[i].pc;
      want.we    = dir_table[i].we;
      want.done  = dir_table[i].done;
      send_item(c, dir_table[i].typed, want);
    end

    for (int p = 0; p < PHASES; p++) begin
      // The register writes can land while a diagonal is still active, which
      // must change the write enable of its remaining pixels.
      drain();
      case (p)
        0: begin w = 4096; h = 4096; end
        1: begin w = 1;    h = 1;    end
        2: begin w = 0;    h = 8191; end
        3: begin w = 640;  h = 480;  end
        4: begin w = 8191; h = 0;    end
        5: begin w = 4096; h = 1;    end
        default: begin
          w = $urandom_range(1, 4096);
          h = $urandom_range(1, 4096);
        end
      endcase
      write_frame_reg(REG_FRAME_WIDTH, w);
      write_frame_reg(REG_FRAME_HEIGHT, h);
      @(negedge clk);
      // One phase runs back to back on both sides.
      no_gaps = (p == 3);
      phase_end = n_sent + ITEMS_PER_PHASE;
      while (n_sent < phase_end) begin
        if ($urandom_range(9) == 0) begin
          // Noise: an item with every field random.
          rnd = {$urandom(), $urandom(), $urandom()};
          c = rnd[$bits(line_cmd_t)-1:0];
          send_item(c);
        end else begin
          run_line();
        end
      end
      no_gaps = 1'b0;
    end

    drain();
    repeat (10) @(posedge clk);
    if (n_errors == 0 && pixels_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
